// ===== hw/rtl/ulcd_pkg.sv =====
package ulcd_pkg;

  localparam int LINE_LEN = 16;
  localparam int POS_W = $clog2(LINE_LEN);
  localparam int DECODE_LEN = 6;

  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_RESET = 3'd3,
    CMD_PWM   = 3'd4,
    CMD_ERROR = 3'd5
  } cmd_t;

  typedef logic [DECODE_LEN-1:0][7:0] line_head_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       line_done;
    logic [2:0] command_code;
    logic [6:0] duty_value;
  } result_t;

  function automatic logic digit_char(input logic [7:0] c);
    digit_char = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ===== hw/rtl/ulcd_in_if.sv =====
interface ulcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/ulcd_out_if.sv =====
interface ulcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic       line_done;
  logic [2:0] command_code;
  logic [6:0] duty_value;

  modport source (output valid, output echo_byte, output line_done, output command_code,
                  output duty_value, input ready);
  modport sink (input valid, input echo_byte, input line_done, input command_code,
                input duty_value, output ready);
endinterface

// ===== hw/rtl/uart_line_command_decoder.sv =====
// A byte is held in the input register, then its result in the result
// register; both hold while results are held off.
// Throughput: one byte per cycle while results are taken; the decode of a
// whole line is done in the single pass that handles its LF byte.
// Reset: synchronous, active high; empties both registers and sets the write
// position to the start of a line.
module uart_line_command_decoder
  import ulcd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  ulcd_in_if.sink  rx,
  ulcd_out_if.source result
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_go;
  logic       out_valid;
  result_t    out_res;
  result_t    dec_res;
  line_head_t head;

  assign s1_go = s1_valid && (!out_valid || result.ready);
  assign rx.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
    end
  end

  ulcd_line_store u_store (
    .clk  (clk),
    .rst  (rst),
    .en   (s1_go),
    .data (s1_byte),
    .head (head)
  );

  ulcd_decode u_decode (
    .data (s1_byte),
    .head (head),
    .res  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res <= dec_res;
    end
  end

  assign result.valid = out_valid;
  assign result.echo_byte = out_res.echo_byte;
  assign result.line_done = out_res.line_done;
  assign result.command_code = out_res.command_code;
  assign result.duty_value = out_res.duty_value;

endmodule

// ===== hw/rtl/ulcd_line_store.sv =====
module ulcd_line_store
  import ulcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] data,
  output line_head_t head
);

  // Only the first characters of a line take part in decoding, so only
  // those are kept; the write position counts to LINE_LEN - 1, then wraps.
  logic [POS_W-1:0] write_position;
  logic [7:0] line_store [DECODE_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
    end else if (en) begin
      if (data == CHAR_LF) begin
        write_position <= '0;
      end else if (write_position < POS_W'(LINE_LEN - 1)) begin
        write_position <= write_position + POS_W'(1);
      end else begin
        write_position <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && data != CHAR_LF) begin
      for (int i = 0; i < DECODE_LEN; i++) begin
        if (write_position == POS_W'(i)) begin
          line_store[i] <= data;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DECODE_LEN; i++) begin
      head[i] = (POS_W'(i) < write_position) ? line_store[i] : CHAR_NUL;
    end
  end

endmodule

// ===== hw/rtl/ulcd_decode.sv =====
module ulcd_decode
  import ulcd_pkg::*;
(
  input  logic [7:0] data,
  input  line_head_t head,
  output result_t    res
);

  logic       is_start;
  logic       is_stop;
  logic       is_reset;
  logic       is_pwm;
  logic [6:0] tens;
  logic [6:0] ones;
  logic [6:0] duty;

  always_comb begin
    is_start = head[0] == 8'h53 && head[1] == 8'h54 && head[2] == 8'h41 &&
               head[3] == 8'h52 && head[4] == 8'h54 && head[5] == CHAR_NUL;
    is_stop  = head[0] == 8'h53 && head[1] == 8'h54 && head[2] == 8'h4F &&
               head[3] == 8'h50 && head[4] == CHAR_NUL;
    is_reset = head[0] == 8'h52 && head[1] == 8'h45 && head[2] == 8'h53 &&
               head[3] == 8'h45 && head[4] == 8'h54 && head[5] == CHAR_NUL;
    is_pwm   = head[0] == 8'h50 && head[1] == 8'h57 && head[2] == 8'h4D &&
               head[3] == CHAR_SPACE;

    tens = {3'd0, head[4][3:0]};
    ones = {3'd0, head[5][3:0]};
    duty = '0;
    if (digit_char(head[4])) begin
      if (digit_char(head[5])) begin
        duty = (tens << 3) + (tens << 1) + ones;
      end else begin
        duty = tens;
      end
    end

    res.echo_byte = data;
    res.line_done = 1'b0;
    res.command_code = CMD_NONE;
    res.duty_value = '0;
    if (data == CHAR_LF) begin
      res.line_done = 1'b1;
      if (is_start) begin
        res.command_code = CMD_START;
      end else if (is_stop) begin
        res.command_code = CMD_STOP;
      end else if (is_reset) begin
        res.command_code = CMD_RESET;
      end else if (is_pwm) begin
        res.command_code = CMD_PWM;
        res.duty_value = duty;
      end else begin
        res.command_code = CMD_ERROR;
      end
    end
  end

endmodule
